// ===== hw/rtl/pidaw_pkg.sv =====
package pidaw_pkg;

  localparam int DATA_WIDTH_DEF     = 32;
  localparam int FRAC_BITS_DEF      = 16;
  localparam int INTEGRAL_WIDTH_DEF = 48;

  localparam int W64   = 64;
  localparam int DIG_W = 16;
  localparam int NDIG  = W64 / DIG_W;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_DERIV_GAIN  = 3'd2,
    CFG_INTEG_UPPER = 3'd3,
    CFG_INTEG_LOWER = 3'd4,
    CFG_DRIVE_UPPER = 3'd5,
    CFG_DRIVE_LOWER = 3'd6
  } cfg_idx_e;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_BAD = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_GET_P,
    ST_MUL_E,
    ST_INTEG,
    ST_MUL_I,
    ST_CLAMP,
    ST_DIV_I,
    ST_GET_IQ,
    ST_DERIV,
    ST_DIV_R,
    ST_GET_R,
    ST_MUL_D,
    ST_GET_D,
    ST_SUM,
    ST_DRIVE,
    ST_DONE
  } state_e;

endpackage

// ===== hw/rtl/pid_controller_antiwindup.sv =====
// Channel   | Direction | Handshake                      | Payload
// s_axis    | in        | s_axis_tvalid_i/s_axis_tready_o | tdata: target, measured, time_step
//           |           |                                | tuser: operation
// m_axis    | out       | m_axis_tvalid_o/m_axis_tready_i | tdata: drive; tuser: status
// cfg       | in        | cfg_valid_i/cfg_ready_o         | cfg_index_i, cfg_data_i
//
// A clear beat or a beat with time_step <= 0 passes through the done state to the output register.
// An update forms the proportional, error-times-step and integral products; when the integral
// term clamps with nonzero integ_gain, a divide recomputes the integral sum, and after the first
// sample a divide and a product form the derivative term. One shared 33x17 multiplier and one
// radix-2 divider of DVW = min(64, DATA_WIDTH + FRAC_BITS + 1) bits, 49 by default, do this work.
// Reset clears the controller state and loads register reset values; no clearing pass.
// The input stalls while a beat is in work; a finished result waits in the output register.
module pid_controller_antiwindup #(
  parameter int DATA_WIDTH     = pidaw_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS      = pidaw_pkg::FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH = pidaw_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // target, measured, time_step (from bit 0 up), zero padded
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,
  // operation
  input  logic [0:0]                             s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // drive, zero padded
  output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata_o,
  // status
  output logic [0:0]                             m_axis_tuser_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [DATA_WIDTH-1:0]                  cfg_data_i
);

  localparam int DW    = DATA_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int IW    = INTEGRAL_WIDTH;
  localparam int W64   = pidaw_pkg::W64;
  localparam int DIG_W = pidaw_pkg::DIG_W;
  localparam int NDIG  = pidaw_pkg::NDIG;
  localparam int ODW   = ((DW + 7) / 8) * 8;
  localparam int AW    = DW + 1;
  localparam int ACW   = AW + DIG_W + 2;
  localparam int LOWW  = DIG_W * (NDIG - 1);
  localparam int PW    = ACW + LOWW;
  localparam int DVW   = (DW + 1 + FB > W64) ? W64 : DW + 1 + FB;
  localparam int XW    = 2 * W64 + 4;
  localparam int MCW   = $clog2(NDIG);
  localparam int DVCW  = $clog2(DVW);

  localparam logic signed [XW-1:0] XMAX64 = XW'({1'b0, {(W64-1){1'b1}}});
  localparam logic signed [XW-1:0] XMIN64 = ~XMAX64;
  localparam logic signed [XW-1:0] XMAXIW = XW'({1'b0, {(IW-1){1'b1}}});
  localparam logic signed [XW-1:0] XMINIW = ~XMAXIW;
  localparam logic signed [XW-1:0] XMAXDV = XW'({1'b0, {(DVW-1){1'b1}}});
  localparam logic signed [XW-1:0] XMINDV = ~XMAXDV;
  localparam logic signed [DW-1:0] DMAX   = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN   = ~DMAX;

  function automatic logic signed [W64-1:0] sat64(input logic signed [XW-1:0] x);
    if (x > XMAX64) return XMAX64[W64-1:0];
    if (x < XMIN64) return XMIN64[W64-1:0];
    return x[W64-1:0];
  endfunction

  function automatic logic signed [IW-1:0] sat_iw(input logic signed [XW-1:0] x);
    if (x > XMAXIW) return XMAXIW[IW-1:0];
    if (x < XMINIW) return XMINIW[IW-1:0];
    return x[IW-1:0];
  endfunction

  function automatic logic signed [DVW-1:0] shl_sat(input logic signed [DW:0] v);
    logic signed [XW-1:0] t;
    t = XW'(v) <<< FB;
    if (t > XMAXDV) return XMAXDV[DVW-1:0];
    if (t < XMINDV) return XMINDV[DVW-1:0];
    return t[DVW-1:0];
  endfunction

  pidaw_pkg::state_e state_q, state_d;

  logic signed [DW-1:0] kp_q, ki_q, kd_q, iup_q, ilo_q, dup_q, dlo_q;

  logic signed [IW-1:0]  isum_q, isum_d;
  logic signed [DW-1:0]  last_q, last_d;
  logic                  first_q, first_d;

  logic signed [DW-1:0]  err_q, err_d, meas_q, meas_d, dt_q, dt_d;
  logic signed [W64-1:0] p_q, p_d, i_q, i_d, d_q, d_d, pi_q, pi_d;
  logic [DW-1:0]         drive_q, drive_d;
  logic                  status_q, status_d;

  logic                  ovld_q, ovld_d;
  logic [DW-1:0]         odata_q, odata_d;
  logic                  ostat_q, ostat_d;

  logic signed [AW-1:0]  mul_a_q, mul_a_d;
  logic [W64-1:0]        mul_b_q, mul_b_d;
  logic signed [ACW-1:0] acc_q, acc_d;
  logic [LOWW-1:0]       low_q, low_d;
  logic [MCW-1:0]        mcnt_q, mcnt_d;

  logic [DVW-1:0]        dv_n_q, dv_n_d;
  logic [DW-1:0]         dv_r_q, dv_r_d, dv_den_q, dv_den_d;
  logic                  dv_neg_q, dv_neg_d;
  logic [DVCW-1:0]       dv_cnt_q, dv_cnt_d;

  logic                  in_acc;
  logic signed [DW-1:0]  in_target, in_measured, in_dt;
  logic signed [DW:0]    diff;
  logic signed [DW-1:0]  err_sat;
  logic signed [DIG_W:0] dig;
  logic signed [AW+DIG_W:0] part;
  logic signed [PW-1:0]  prod;
  logic signed [W64-1:0] mulres;
  logic signed [DVW:0]   q_s;
  logic [DW:0]           rem_sh;
  logic                  mul_step, div_step, div_last, mul_last;
  logic signed [IW-1:0]  isum_new;
  logic signed [W64-1:0] sum_all;

  assign s_axis_tready_o = (state_q == pidaw_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_target       = $signed(s_axis_tdata_i[DW-1:0]);
  assign in_measured     = $signed(s_axis_tdata_i[2*DW-1:DW]);
  assign in_dt           = $signed(s_axis_tdata_i[3*DW-1:2*DW]);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = ODW'(odata_q);
  assign m_axis_tuser_o  = ostat_q;

  assign diff    = (DW+1)'(in_target) - (DW+1)'(in_measured);
  assign err_sat = (diff[DW] != diff[DW-1]) ? (diff[DW] ? DMIN : DMAX) : diff[DW-1:0];

  assign mul_step = (state_q == pidaw_pkg::ST_MUL_P) || (state_q == pidaw_pkg::ST_MUL_E) ||
                    (state_q == pidaw_pkg::ST_MUL_I) || (state_q == pidaw_pkg::ST_MUL_D);
  assign mul_last = (mcnt_q == MCW'(NDIG - 1));
  assign dig      = $signed({mul_last ? mul_b_q[DIG_W-1] : 1'b0, mul_b_q[DIG_W-1:0]});
  assign part     = mul_a_q * dig;
  assign prod     = $signed({acc_q, low_q});
  assign mulres   = sat64(XW'($signed(prod[PW-1:FB])));

  assign div_step = (state_q == pidaw_pkg::ST_DIV_I) || (state_q == pidaw_pkg::ST_DIV_R);
  assign div_last = (dv_cnt_q == DVCW'(DVW - 1));
  assign rem_sh   = {dv_r_q, dv_n_q[DVW-1]};
  assign q_s      = dv_neg_q ? -$signed({1'b0, dv_n_q}) : $signed({1'b0, dv_n_q});

  assign isum_new = sat_iw(XW'(isum_q) + XW'(mulres));
  assign sum_all  = sat64(XW'(pi_q) + XW'(d_q));

  always_comb begin
    logic signed [DVW-1:0] dvn;
    logic signed [DW-1:0]  dvd;
    logic                  dv_load;
    logic signed [DW-1:0]  lim;
    state_d  = state_q;
    isum_d   = isum_q;
    last_d   = last_q;
    first_d  = first_q;
    err_d    = err_q;
    meas_d   = meas_q;
    dt_d     = dt_q;
    p_d      = p_q;
    i_d      = i_q;
    d_d      = d_q;
    pi_d     = pi_q;
    drive_d  = drive_q;
    status_d = status_q;
    ovld_d   = ovld_q && !m_axis_tready_i;
    odata_d  = odata_q;
    ostat_d  = ostat_q;
    mul_a_d  = mul_a_q;
    mul_b_d  = mul_b_q;
    acc_d    = acc_q;
    low_d    = low_q;
    mcnt_d   = '0;
    dv_n_d   = dv_n_q;
    dv_r_d   = dv_r_q;
    dv_den_d = dv_den_q;
    dv_neg_d = dv_neg_q;
    dv_cnt_d = '0;
    dvn      = '0;
    dvd      = '0;
    dv_load  = 1'b0;
    lim      = iup_q;

    if (mul_step) begin
      acc_d   = ((mcnt_q == '0) ? ACW'(0) : (acc_q >>> DIG_W)) + ACW'(part);
      if (mcnt_q != '0) low_d = {acc_q[DIG_W-1:0], low_q[LOWW-1:DIG_W]};
      mul_b_d = mul_b_q >> DIG_W;
      mcnt_d  = mcnt_q + MCW'(1);
    end
    if (div_step) begin
      if (rem_sh >= {1'b0, dv_den_q}) begin
        dv_r_d = DW'(rem_sh - {1'b0, dv_den_q});
        dv_n_d = {dv_n_q[DVW-2:0], 1'b1};
      end else begin
        dv_r_d = rem_sh[DW-1:0];
        dv_n_d = {dv_n_q[DVW-2:0], 1'b0};
      end
      dv_cnt_d = dv_cnt_q + DVCW'(1);
    end

    case (state_q)
      pidaw_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i[0] == pidaw_pkg::OP_CLEAR) begin
            isum_d   = '0;
            last_d   = '0;
            first_d  = 1'b1;
            drive_d  = '0;
            status_d = pidaw_pkg::STAT_OK;
            state_d  = pidaw_pkg::ST_DONE;
          end else if (in_dt <= $signed(DW'(0))) begin
            drive_d  = '0;
            status_d = pidaw_pkg::STAT_BAD;
            state_d  = pidaw_pkg::ST_DONE;
          end else begin
            err_d   = err_sat;
            meas_d  = in_measured;
            dt_d    = in_dt;
            mul_a_d = AW'(kp_q);
            mul_b_d = W64'(err_sat);
            state_d = pidaw_pkg::ST_MUL_P;
          end
        end
      end
      pidaw_pkg::ST_MUL_P: if (mul_last) state_d = pidaw_pkg::ST_GET_P;
      pidaw_pkg::ST_GET_P: begin
        p_d     = mulres;
        mul_a_d = AW'(err_q);
        mul_b_d = W64'(dt_q);
        state_d = pidaw_pkg::ST_MUL_E;
      end
      pidaw_pkg::ST_MUL_E: if (mul_last) state_d = pidaw_pkg::ST_INTEG;
      pidaw_pkg::ST_INTEG: begin
        isum_d  = isum_new;
        mul_a_d = AW'(ki_q);
        mul_b_d = W64'(isum_new);
        state_d = pidaw_pkg::ST_MUL_I;
      end
      pidaw_pkg::ST_MUL_I: if (mul_last) state_d = pidaw_pkg::ST_CLAMP;
      pidaw_pkg::ST_CLAMP: begin
        state_d = pidaw_pkg::ST_DERIV;
        if (mulres > W64'(iup_q) || mulres < W64'(ilo_q)) begin
          lim = (mulres > W64'(iup_q)) ? iup_q : ilo_q;
          i_d = W64'(lim);
          if (ki_q != '0) begin
            dvn     = shl_sat((DW+1)'(lim));
            dvd     = ki_q;
            dv_load = 1'b1;
            state_d = pidaw_pkg::ST_DIV_I;
          end else begin
            isum_d = '0;
          end
        end else begin
          i_d = mulres;
        end
      end
      pidaw_pkg::ST_DIV_I: if (div_last) state_d = pidaw_pkg::ST_GET_IQ;
      pidaw_pkg::ST_GET_IQ: begin
        isum_d  = sat_iw(XW'(q_s));
        state_d = pidaw_pkg::ST_DERIV;
      end
      pidaw_pkg::ST_DERIV: begin
        last_d = meas_q;
        if (first_q) begin
          first_d = 1'b0;
          d_d     = '0;
          state_d = pidaw_pkg::ST_SUM;
        end else begin
          dvn     = shl_sat((DW+1)'(meas_q) - (DW+1)'(last_q));
          dvd     = dt_q;
          dv_load = 1'b1;
          state_d = pidaw_pkg::ST_DIV_R;
        end
      end
      pidaw_pkg::ST_DIV_R: if (div_last) state_d = pidaw_pkg::ST_GET_R;
      pidaw_pkg::ST_GET_R: begin
        mul_a_d = -AW'(kd_q);
        mul_b_d = sat64(XW'(q_s));
        state_d = pidaw_pkg::ST_MUL_D;
      end
      pidaw_pkg::ST_MUL_D: if (mul_last) state_d = pidaw_pkg::ST_GET_D;
      pidaw_pkg::ST_GET_D: begin
        d_d     = mulres;
        state_d = pidaw_pkg::ST_SUM;
      end
      pidaw_pkg::ST_SUM: begin
        pi_d    = sat64(XW'(p_q) + XW'(i_q));
        state_d = pidaw_pkg::ST_DRIVE;
      end
      pidaw_pkg::ST_DRIVE: begin
        if (sum_all > W64'(dup_q)) drive_d = dup_q;
        else if (sum_all < W64'(dlo_q)) drive_d = dlo_q;
        else drive_d = sum_all[DW-1:0];
        status_d = pidaw_pkg::STAT_OK;
        state_d  = pidaw_pkg::ST_DONE;
      end
      pidaw_pkg::ST_DONE: begin
        if (!ovld_q || m_axis_tready_i) begin
          ovld_d  = 1'b1;
          odata_d = drive_q;
          ostat_d = status_q;
          state_d = pidaw_pkg::ST_IDLE;
        end
      end
      default: state_d = pidaw_pkg::ST_IDLE;
    endcase

    if (dv_load) begin
      dv_neg_d = dvn[DVW-1] ^ dvd[DW-1];
      dv_n_d   = dvn[DVW-1] ? DVW'(-dvn) : DVW'(dvn);
      dv_den_d = dvd[DW-1] ? DW'(-dvd) : DW'(dvd);
      dv_r_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidaw_pkg::ST_IDLE;
      ovld_q  <= 1'b0;
      isum_q  <= '0;
      last_q  <= '0;
      first_q <= 1'b1;
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      iup_q   <= DMAX;
      ilo_q   <= DMIN;
      dup_q   <= DMAX;
      dlo_q   <= DMIN;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      isum_q  <= isum_d;
      last_q  <= last_d;
      first_q <= first_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pidaw_pkg::CFG_PROP_GAIN:   kp_q  <= $signed(cfg_data_i);
          pidaw_pkg::CFG_INTEG_GAIN:  ki_q  <= $signed(cfg_data_i);
          pidaw_pkg::CFG_DERIV_GAIN:  kd_q  <= $signed(cfg_data_i);
          pidaw_pkg::CFG_INTEG_UPPER: iup_q <= $signed(cfg_data_i);
          pidaw_pkg::CFG_INTEG_LOWER: ilo_q <= $signed(cfg_data_i);
          pidaw_pkg::CFG_DRIVE_UPPER: dup_q <= $signed(cfg_data_i);
          pidaw_pkg::CFG_DRIVE_LOWER: dlo_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    err_q    <= err_d;
    meas_q   <= meas_d;
    dt_q     <= dt_d;
    p_q      <= p_d;
    i_q      <= i_d;
    d_q      <= d_d;
    pi_q     <= pi_d;
    drive_q  <= drive_d;
    status_q <= status_d;
    odata_q  <= odata_d;
    ostat_q  <= ostat_d;
    mul_a_q  <= mul_a_d;
    mul_b_q  <= mul_b_d;
    acc_q    <= acc_d;
    low_q    <= low_d;
    mcnt_q   <= mcnt_d;
    dv_n_q   <= dv_n_d;
    dv_r_q   <= dv_r_d;
    dv_den_q <= dv_den_d;
    dv_neg_q <= dv_neg_d;
    dv_cnt_q <= dv_cnt_d;
  end

  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser_i[0] == pidaw_pkg::OP_CLEAR) |=> first_q && (isum_q == '0))
    else $error("clear beat left controller state");

  a_bad_step_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser_i[0] == pidaw_pkg::OP_UPDATE) && (in_dt <= $signed(DW'(0)))
    |=> $stable(isum_q) && $stable(last_q) && $stable(first_q))
    else $error("invalid time step changed state");

  a_integ_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pidaw_pkg::ST_SUM) |-> (i_q <= W64'(iup_q)) || (i_q == W64'(ilo_q)))
    else $error("integral term outside its limits");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == pidaw_pkg::ST_DONE)
    else $error("result beat raised outside done state");

endmodule
